/* rtl/spq_pkg.sv */
// shared constants and types for the stable priority task queue
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 7;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_POPPED   = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic signed [31:0] prio;
    logic [31:0]        handler;
    logic [31:0]        argument;
  } task_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic  ins;
    logic  pop;
    task_t item;
  } spq_cmd_t;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted chain: holds a task and shifts with its neighbors
module spq_cell import spq_pkg::*; (
  input  logic     clk,
  input  spq_cmd_t cmd,
  input  logic     occ,
  input  logic     left_behind,
  input  task_t    left_task,
  input  task_t    right_task,
  output logic     behind,
  output task_t    cell_task
);

  task_t cell_r;

  // new task goes behind every occupied slot of equal or higher priority
  assign behind    = occ && ($signed(cell_r.prio) >= $signed(cmd.item.prio));
  assign cell_task = cell_r;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!behind) begin
        cell_r <= left_behind ? cmd.item : left_task;
      end
    end else if (cmd.pop) begin
      cell_r <= right_task;
    end
  end

endmodule

/* rtl/stable_priority_task_queue.sv */
// a result word appears in the cycle after its input word is accepted
// one word per cycle unless stalled; all shifting cells move in that cycle
// ready drops only while a finished result waits on a stalled output
// reset (rst_n, synchronous, active low) empties the queue and the output
// slot contents are left as they are and never read before written
module stable_priority_task_queue import spq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [31:0] in_priority_req,
  input  logic [31:0]        in_handler,
  input  logic [31:0]        in_argument,
  input  logic signed [31:0] in_running_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_priority,
  output logic [31:0]        out_handler,
  output logic [31:0]        out_argument,
  output logic [OCC_W-1:0]   out_occupancy
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [2:0]       status_r, status_nxt;
  task_t            res_r, res_nxt;
  logic [OCC_W-1:0] occ_r;

  spq_cmd_t cmd;
  task_t    cell_task [QUEUE_DEPTH];
  logic     behind    [QUEUE_DEPTH];
  logic     accept, do_ins, do_pop;
  task_t    head;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign head     = cell_task[0];

  assign do_ins = accept && !in_mode && (in_handler != 32'd0)
               && (count_r < CNT_W'(QUEUE_DEPTH));
  assign do_pop = accept && in_mode && (count_r != '0)
               && ($signed(head.prio) >= $signed(in_running_priority));

  assign cmd.ins           = do_ins;
  assign cmd.pop           = do_pop;
  assign cmd.item.prio     = in_priority_req;
  assign cmd.item.handler  = in_handler;
  assign cmd.item.argument = in_argument;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  occ;
    logic  lb;
    task_t lt, rt;
    assign occ = count_r > CNT_W'(i);
    if (i == 0) begin : g_first
      assign lb = 1'b0;
      assign lt = cmd.item;
    end else begin : g_mid
      assign lb = behind[i-1];
      assign lt = cell_task[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rt = cell_task[i];
    end else begin : g_inner
      assign rt = cell_task[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ),
      .left_behind(lb),
      .left_task  (lt),
      .right_task (rt),
      .behind     (behind[i]),
      .cell_task  (cell_task[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    res_nxt    = '0;
    status_nxt = ST_NONE;
    priority if (!in_mode && in_handler == 32'd0) begin
      status_nxt = ST_NULL;
    end else if (!in_mode && !do_ins) begin
      status_nxt = ST_FULL;
    end else if (!in_mode) begin
      status_nxt = ST_INSERTED;
      count_nxt  = count_r + CNT_W'(1);
    end else if (do_pop) begin
      status_nxt = ST_POPPED;
      res_nxt    = head;
      count_nxt  = count_r - CNT_W'(1);
    end else begin
      status_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_priority  = res_r.prio;
  assign out_handler   = res_r.handler;
  assign out_argument  = res_r.argument;
  assign out_occupancy = occ_r;

endmodule

/* rtl/spq_checker.sv */
// port-level checks for the stable priority task queue, bound to the top
module spq_checker import spq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic [31:0]        in_handler,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_priority,
  input logic [31:0]        out_handler,
  input logic [31:0]        out_argument,
  input logic [OCC_W-1:0]   out_occupancy
);

  // every accepted word yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted word");

  // a null handler insert is always reported as such
  a_null_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode && in_handler == 32'd0
    |=> out_status == ST_NULL)
    else $error("null handler not rejected");

  // only a popped result carries a task, and that task has a handler
  a_task_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_POPPED) ? (out_handler != 32'd0)
      : (out_priority == 32'sd0 && out_handler == 32'd0 && out_argument == 32'd0))
    else $error("result task fields inconsistent with status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_occupancy))
    else $error("stalled result changed");

endmodule

bind stable_priority_task_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_mode      (in_mode),
  .in_handler   (in_handler),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_priority (out_priority),
  .out_handler  (out_handler),
  .out_argument (out_argument),
  .out_occupancy(out_occupancy)
);
